>>> hw/rtl/sttr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sttr_pkg;

  // Table sizes.
  localparam int unsigned TimerSlots = 8;
  localparam int unsigned SchedSlots = 8;
  localparam int unsigned TIdxW = (TimerSlots > 1) ? $clog2(TimerSlots) : 1;
  localparam int unsigned SIdxW = (SchedSlots > 1) ? $clog2(SchedSlots) : 1;

  // Result buffer for one tick.
  localparam int unsigned MaxResults = 8;
  localparam int unsigned RIdxW = $clog2(MaxResults);

  // Field widths.
  localparam int unsigned IdW = 8;
  localparam int unsigned DelayW = 15;
  localparam int unsigned RunsW = 7;
  localparam int unsigned TickW = 8;
  localparam int unsigned CntW = 4;

  localparam logic [TickW-1:0] TickReset = 8'd10;

  // Item modes.
  localparam logic [2:0] ModeTick = 3'd0;
  localparam logic [2:0] ModeArmOnce = 3'd1;
  localparam logic [2:0] ModeArmRep = 3'd2;
  localparam logic [2:0] ModeRmTimer = 3'd3;
  localparam logic [2:0] ModeRmSched = 3'd4;
  localparam logic [2:0] ModeQuery = 3'd5;

  // Status bits.
  localparam int unsigned StatTimerFull = 0;
  localparam int unsigned StatSchedFull = 1;

  // Summary of one finished item, handed to the result stage.
  typedef struct packed {
    logic            start;
    logic [1:0]      status;
    logic            hit;
    logic [CntW-1:0] nt;
    logic [CntW-1:0] ns;
  } emit_req_t;

  // One expiry reported during a tick.
  typedef struct packed {
    logic           valid;
    logic [IdW-1:0] owner;
  } fire_push_t;

endpackage

`default_nettype wire

>>> hw/rtl/sttr_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Input item channel.
interface sttr_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [7:0]  task_id;
  logic [14:0] delay_ms;
  logic [6:0]  repeat_count;

  modport source (output valid, mode, task_id, delay_ms, repeat_count, input ready);
  modport sink (input valid, mode, task_id, delay_ms, repeat_count, output ready);
endinterface

// Result channel.
interface sttr_out_if;
  logic       valid;
  logic       ready;
  logic       fired;
  logic [7:0] fired_task;
  logic [1:0] status;
  logic       is_scheduled;
  logic [3:0] active_timers;
  logic [3:0] active_schedules;
  logic       last;

  modport source (output valid, fired, fired_task, status, is_scheduled, active_timers,
                  active_schedules, last, input ready);
  modport sink (input valid, fired, fired_task, status, is_scheduled, active_timers,
                active_schedules, last, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/sttr_ram.sv
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM with one registered read port.
module sttr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

>>> hw/rtl/sttr_emit.sv
`timescale 1ns / 1ps
`default_nettype none

// Collects expiries of a tick and sends the results of an item through an
// output register.
module sttr_emit (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire sttr_pkg::fire_push_t   push_i,
  input  wire sttr_pkg::emit_req_t    req_i,
  output logic                        busy_o,
  sttr_out_if.source                  result_o
);
  import sttr_pkg::*;

  logic [IdW-1:0]   buf_q [MaxResults];
  logic [CntW-1:0]  nf_q, nf_d;
  logic [RIdxW-1:0] k_q, k_d;
  logic             busy_q, busy_d;
  emit_req_t        sum_q;
  logic             out_valid_q, out_valid_d;
  logic             load, is_last;

  logic             o_fired_q;
  logic [IdW-1:0]   o_task_q;
  logic [1:0]       o_status_q;
  logic             o_hit_q;
  logic [CntW-1:0]  o_nt_q, o_ns_q;
  logic             o_last_q;

  // A result is loaded when the output register is free or being drained.
  assign load = busy_q && (!out_valid_q || result_o.ready);
  assign is_last = (nf_q == '0) || ({1'b0, k_q} == CntW'(nf_q - 1'b1));

  always_comb begin
    nf_d = nf_q;
    k_d = k_q;
    busy_d = busy_q;
    out_valid_d = out_valid_q;
    if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (push_i.valid && (nf_q < CntW'(MaxResults))) begin
      nf_d = nf_q + 1'b1;
    end
    if (req_i.start) begin
      busy_d = 1'b1;
      k_d = '0;
    end
    if (load) begin
      out_valid_d = 1'b1;
      k_d = k_q + 1'b1;
      if (is_last) begin
        busy_d = 1'b0;
        nf_d = '0;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nf_q <= '0;
      k_q <= '0;
      busy_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      nf_q <= nf_d;
      k_q <= k_d;
      busy_q <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Expiry buffer and item summary.
  always_ff @(posedge clk_i) begin
    if (push_i.valid && (nf_q < CntW'(MaxResults))) begin
      buf_q[nf_q[RIdxW-1:0]] <= push_i.owner;
    end
    if (req_i.start) begin
      sum_q <= req_i;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (load) begin
      o_fired_q <= (nf_q != '0);
      o_task_q <= (nf_q != '0) ? buf_q[k_q] : '0;
      o_status_q <= sum_q.status;
      o_hit_q <= sum_q.hit;
      o_nt_q <= sum_q.nt;
      o_ns_q <= sum_q.ns;
      o_last_q <= is_last;
    end
  end

  assign busy_o = busy_q;
  assign result_o.valid = out_valid_q;
  assign result_o.fired = o_fired_q;
  assign result_o.fired_task = o_task_q;
  assign result_o.status = o_status_q;
  assign result_o.is_scheduled = o_hit_q;
  assign result_o.active_timers = o_nt_q;
  assign result_o.active_schedules = o_ns_q;
  assign result_o.last = o_last_q;

endmodule

`default_nettype wire

>>> hw/rtl/software_timer_table_with_reload_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Flow: an arm item writes its slots when accepted and then reports; a remove or
// query walks every slot of its table in a read and an evaluate state; a tick walks
// each timer slot alike and, per expired timer, searches schedule entries for a reload.
// Throughput: one item at a time; items are taken only in idle, result stage not busy.
// Reset: valid bits clear at once, tick_ms returns to 10; RAMs need no clearing.
module software_timer_table_with_reload_unit (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i,
  sttr_in_if.sink         item_i,
  sttr_out_if.source      result_o
);
  import sttr_pkg::*;

  localparam int unsigned TW = IdW + DelayW;
  localparam int unsigned SW = IdW + DelayW + RunsW;

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StTRd = 4'd1;
  localparam logic [3:0] StTEv = 4'd2;
  localparam logic [3:0] StSRd = 4'd3;
  localparam logic [3:0] StSEv = 4'd4;
  localparam logic [3:0] StWtRd = 4'd5;
  localparam logic [3:0] StWtEv = 4'd6;
  localparam logic [3:0] StWsRd = 4'd7;
  localparam logic [3:0] StWsEv = 4'd8;
  localparam logic [3:0] StDone = 4'd9;

  logic [3:0]            state_q, state_d;
  logic [TickW-1:0]      tick_q;
  logic [TimerSlots-1:0] armed_q, armed_d;
  logic [SchedSlots-1:0] live_q, live_d;
  logic [TIdxW-1:0]      ti_q, ti_d;
  logic [SIdxW-1:0]      sj_q, sj_d;
  logic [IdW-1:0]        cur_owner_q, cur_owner_d;
  logic [2:0]            mode_q, mode_d;
  logic [IdW-1:0]        id_q, id_d;
  logic [1:0]            status_q, status_d;
  logic                  hit_q, hit_d;

  logic                  t_we, s_we;
  logic [TIdxW-1:0]      t_waddr;
  logic [SIdxW-1:0]      s_waddr;
  logic [TW-1:0]         t_wdata, t_rdata;
  logic [SW-1:0]         s_wdata, s_rdata;

  logic [IdW-1:0]        t_owner, s_owner;
  logic [DelayW-1:0]     t_rem, s_period;
  logic [RunsW-1:0]      s_runs;

  logic [TIdxW-1:0]      t_free;
  logic                  t_free_ok;
  logic [SIdxW-1:0]      s_free;
  logic                  s_free_ok;
  logic [CntW-1:0]       nt, ns;
  logic                  accept, emit_busy, s_match;
  fire_push_t            push;
  emit_req_t             req;

  assign t_owner = t_rdata[TW-1 -: IdW];
  assign t_rem = t_rdata[DelayW-1:0];
  assign s_owner = s_rdata[SW-1 -: IdW];
  assign s_period = s_rdata[RunsW +: DelayW];
  assign s_runs = s_rdata[RunsW-1:0];

  assign item_i.ready = (state_q == StIdle) && !emit_busy;
  assign accept = item_i.valid && item_i.ready;

  // Schedule entry that reloads the current timer.
  assign s_match = live_q[sj_q] && (s_owner == cur_owner_q) && (s_runs != RunsW'(1));

  // First free slots and occupancy counts.
  always_comb begin
    t_free = '0;
    t_free_ok = 1'b0;
    nt = '0;
    for (int i = TimerSlots - 1; i >= 0; i--) begin
      if (!armed_q[i]) begin
        t_free = TIdxW'(i);
        t_free_ok = 1'b1;
      end
      nt = nt + CntW'(armed_q[i]);
    end
  end

  always_comb begin
    s_free = '0;
    s_free_ok = 1'b0;
    ns = '0;
    for (int i = SchedSlots - 1; i >= 0; i--) begin
      if (!live_q[i]) begin
        s_free = SIdxW'(i);
        s_free_ok = 1'b1;
      end
      ns = ns + CntW'(live_q[i]);
    end
  end

  // Sequencer over the timer and schedule RAMs.
  always_comb begin
    state_d = state_q;
    armed_d = armed_q;
    live_d = live_q;
    ti_d = ti_q;
    sj_d = sj_q;
    cur_owner_d = cur_owner_q;
    mode_d = mode_q;
    id_d = id_q;
    status_d = status_q;
    hit_d = hit_q;
    t_we = 1'b0;
    t_waddr = ti_q;
    t_wdata = '0;
    s_we = 1'b0;
    s_waddr = sj_q;
    s_wdata = '0;
    push = '0;
    req = '0;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          mode_d = item_i.mode;
          id_d = item_i.task_id;
          status_d = '0;
          hit_d = 1'b0;
          ti_d = '0;
          sj_d = '0;
          state_d = StDone;
          if (item_i.mode == ModeTick) begin
            state_d = StTRd;
          end else if (item_i.task_id != '0) begin
            case (item_i.mode) inside
              ModeArmOnce, ModeArmRep: begin
                if (t_free_ok) begin
                  t_we = 1'b1;
                  t_waddr = t_free;
                  t_wdata = {item_i.task_id, item_i.delay_ms};
                  armed_d[t_free] = 1'b1;
                end else begin
                  status_d[StatTimerFull] = 1'b1;
                end
                if (item_i.mode == ModeArmRep) begin
                  if (s_free_ok) begin
                    s_we = 1'b1;
                    s_waddr = s_free;
                    s_wdata = {item_i.task_id, item_i.delay_ms, item_i.repeat_count};
                    live_d[s_free] = 1'b1;
                  end else begin
                    status_d[StatSchedFull] = 1'b1;
                  end
                end
              end
              ModeRmTimer: state_d = StWtRd;
              ModeRmSched, ModeQuery: state_d = StWsRd;
              default: state_d = StDone;
            endcase
          end
        end
      end
      StTRd: state_d = StTEv;
      StTEv: begin
        if (armed_q[ti_q] && (t_rem <= DelayW'(tick_q))) begin
          push.valid = 1'b1;
          push.owner = t_owner;
          cur_owner_d = t_owner;
          sj_d = '0;
          state_d = StSRd;
        end else begin
          if (armed_q[ti_q]) begin
            t_we = 1'b1;
            t_wdata = {t_owner, DelayW'(t_rem - DelayW'(tick_q))};
          end
          if (ti_q == TIdxW'(TimerSlots - 1)) begin
            state_d = StDone;
          end else begin
            ti_d = ti_q + 1'b1;
            state_d = StTRd;
          end
        end
      end
      StSRd: state_d = StSEv;
      StSEv: begin
        if (s_match || (sj_q == SIdxW'(SchedSlots - 1))) begin
          if (s_match) begin
            t_we = 1'b1;
            t_wdata = {cur_owner_q, s_period};
            if (s_period == '0) begin
              armed_d[ti_q] = 1'b0;
            end
            if (s_runs > RunsW'(2)) begin
              s_we = 1'b1;
              s_wdata = {s_owner, s_period, RunsW'(s_runs - 1'b1)};
            end else if (s_runs == RunsW'(2)) begin
              live_d[sj_q] = 1'b0;
            end
          end else begin
            armed_d[ti_q] = 1'b0;
          end
          if (ti_q == TIdxW'(TimerSlots - 1)) begin
            state_d = StDone;
          end else begin
            ti_d = ti_q + 1'b1;
            state_d = StTRd;
          end
        end else begin
          sj_d = sj_q + 1'b1;
          state_d = StSRd;
        end
      end
      StWtRd: state_d = StWtEv;
      StWtEv: begin
        if (armed_q[ti_q] && (t_owner == id_q)) begin
          armed_d[ti_q] = 1'b0;
        end
        if (ti_q == TIdxW'(TimerSlots - 1)) begin
          state_d = StDone;
        end else begin
          ti_d = ti_q + 1'b1;
          state_d = StWtRd;
        end
      end
      StWsRd: state_d = StWsEv;
      StWsEv: begin
        if (live_q[sj_q] && (s_owner == id_q)) begin
          if (mode_q == ModeRmSched) begin
            live_d[sj_q] = 1'b0;
          end else begin
            hit_d = 1'b1;
          end
        end
        if (sj_q == SIdxW'(SchedSlots - 1)) begin
          state_d = StDone;
        end else begin
          sj_d = sj_q + 1'b1;
          state_d = StWsRd;
        end
      end
      StDone: begin
        req.start = 1'b1;
        req.status = status_q;
        req.hit = hit_q;
        req.nt = nt;
        req.ns = ns;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // Control state and tick register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      tick_q <= TickReset;
      armed_q <= '0;
      live_q <= '0;
      ti_q <= '0;
      sj_q <= '0;
      status_q <= '0;
      hit_q <= 1'b0;
      mode_q <= ModeTick;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        tick_q <= cfg_wdata_i;
      end
      armed_q <= armed_d;
      live_q <= live_d;
      ti_q <= ti_d;
      sj_q <= sj_d;
      status_q <= status_d;
      hit_q <= hit_d;
      mode_q <= mode_d;
    end
  end

  // Item payload held during the walk.
  always_ff @(posedge clk_i) begin
    id_q <= id_d;
    cur_owner_q <= cur_owner_d;
  end

  // Timer RAM: owner and remaining time.
  sttr_ram #(.Width(TW), .Depth(TimerSlots)) u_timer_ram (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .waddr_i (t_waddr),
    .wdata_i (t_wdata),
    .raddr_i (ti_q),
    .rdata_o (t_rdata)
  );

  // Schedule RAM: owner, period and runs left.
  sttr_ram #(.Width(SW), .Depth(SchedSlots)) u_sched_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .raddr_i (sj_q),
    .rdata_o (s_rdata)
  );

  // Result stage.
  sttr_emit u_emit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .req_i    (req),
    .busy_o   (emit_busy),
    .result_o (result_o)
  );

  // A tick never adds schedule entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSEv) |=> ($countones(live_q) <= $countones($past(live_q))))
    else $error("tick walk added a schedule entry");

  // A one-shot arm with a free slot adds exactly one armed timer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (item_i.mode == ModeArmOnce) && (item_i.task_id != '0) && t_free_ok)
    |=> ($countones(armed_q) == $countones($past(armed_q)) + 1))
    else $error("arm did not take exactly one timer slot");

  // The timer evaluate states and the remove and query walks never write the schedule RAM.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == StTEv) || (state_q == StWtEv) || (state_q == StWsEv)) |-> !s_we)
    else $error("schedule RAM written outside arm or reload");

endmodule

`default_nettype wire
